FILE: rtl/khrs_pkg.sv
// shared constants and types for the k-mer hit run segmenter
package khrs_pkg;

  localparam int unsigned NODE_W      = 32;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned ID_W        = 40;
  localparam int unsigned RID_W       = 40;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
  localparam logic [COUNT_W-1:0] MIN_MATCHES_RST = COUNT_W'(4);
  localparam logic [ID_W-1:0]    FIRST_ID        = ID_W'(1);
  localparam logic [ID_W-1:0]    ID_STEP         = ID_W'(2);

  typedef struct packed {
    logic signed [NODE_W-1:0] node;
    logic                     reverse;
    logic [POS_W-1:0]         start_pos;
    logic [POS_W-1:0]         end_pos;
    logic [COUNT_W-1:0]       count;
  } seg_t;

  // results of one input item: segment closed by a node change, then by read end
  typedef struct packed {
    logic             has_a;
    seg_t             seg_a;
    logic             has_b;
    seg_t             seg_b;
    logic             read_end;
    logic [RID_W-1:0] read_index;
  } q_entry_t;

endpackage

FILE: rtl/khrs_if.sv
// channel interfaces for k-mer hits, configuration writes and segments
interface khrs_in_if;
  import khrs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [NODE_W-1:0] hit_node;
  logic [POS_W-1:0]         hit_pos;
  logic                     kmer_forward;
  logic [RID_W-1:0]         read_index;
  logic                     read_end;

  modport source (
    output valid, hit, hit_node, hit_pos, kmer_forward, read_index, read_end,
    input  ready
  );
  modport sink (
    input  valid, hit, hit_node, hit_pos, kmer_forward, read_index, read_end,
    output ready
  );
endinterface

interface khrs_cfg_if;
  import khrs_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] min_count;

  modport source (output valid, min_count, input ready);
  modport sink (input valid, min_count, output ready);
endinterface

interface khrs_out_if;
  import khrs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     seg_valid;
  logic signed [NODE_W-1:0] seg_node;
  logic                     seg_reverse;
  logic [POS_W-1:0]         seg_first_pos;
  logic [POS_W-1:0]         seg_last_pos;
  logic [COUNT_W-1:0]       seg_count;
  logic [ID_W-1:0]          mapped_id;
  logic [RID_W-1:0]         out_read_index;
  logic                     read_done;

  modport source (
    output valid, seg_valid, seg_node, seg_reverse, seg_first_pos, seg_last_pos,
           seg_count, mapped_id, out_read_index, read_done,
    input  ready
  );
  modport sink (
    input  valid, seg_valid, seg_node, seg_reverse, seg_first_pos, seg_last_pos,
           seg_count, mapped_id, out_read_index, read_done,
    output ready
  );
endinterface

FILE: rtl/khrs_front.sv
// front end: accepts hits, tracks the open segment and queues closed segments
module khrs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  khrs_in_if.sink             in_i,
  khrs_cfg_if.sink            cfg_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output khrs_pkg::q_entry_t  q_data_o
);
  import khrs_pkg::*;

  seg_t               cur_q, cur_d;
  seg_t               mid;
  logic [COUNT_W-1:0] min_count_q;
  logic               accept;
  logic               hit_ok;
  logic               rep_a;
  logic               rep_b;

  assign in_i.ready  = !q_full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign hit_ok      = in_i.hit && (in_i.hit_node != '0);

  always_comb begin
    mid   = cur_q;
    rep_a = 1'b0;
    if (hit_ok) begin
      if (cur_q.node == '0) begin
        mid.reverse   = in_i.hit_node[NODE_W-1] ^ ~in_i.kmer_forward;
        mid.node      = in_i.hit_node;
        mid.start_pos = in_i.hit_pos;
        mid.end_pos   = in_i.hit_pos;
        mid.count     = COUNT_W'(1);
      end else if (in_i.hit_node != cur_q.node) begin
        rep_a         = cur_q.count >= min_count_q;
        mid.node      = in_i.hit_node;
        mid.start_pos = in_i.hit_pos;
        mid.end_pos   = in_i.hit_pos;
        mid.count     = COUNT_W'(1);
      end else begin
        if (cur_q.count != COUNT_MAX) begin
          mid.count = cur_q.count + COUNT_W'(1);
        end
        mid.end_pos = in_i.hit_pos;
      end
    end
    rep_b = in_i.read_end && (mid.node != '0) && (mid.count >= min_count_q);
  end

  always_comb begin
    cur_d = cur_q;
    if (accept) begin
      cur_d = in_i.read_end ? '0 : mid;
    end
  end

  assign q_push_o            = accept && (rep_a || in_i.read_end);
  assign q_data_o.has_a      = rep_a;
  assign q_data_o.seg_a      = cur_q;
  assign q_data_o.has_b      = rep_b;
  assign q_data_o.seg_b      = mid;
  assign q_data_o.read_end   = in_i.read_end;
  assign q_data_o.read_index = in_i.read_index;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      min_count_q <= MIN_MATCHES_RST;
    end else begin
      cur_q <= cur_d;
      if (cfg_i.valid && cfg_i.ready) begin
        min_count_q <= cfg_i.min_count;
      end
    end
  end

  a_open_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q.node != '0) |-> (cur_q.count != '0))
    else $error("open segment with zero count");

  a_closed_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q.node == '0) |-> (cur_q.count == '0))
    else $error("count held with no open segment");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.read_end) |=> (cur_q.node == '0))
    else $error("segment left open after read end");

endmodule

FILE: rtl/khrs_queue.sv
// short queue between front and back end
module khrs_queue #(
  parameter int unsigned DEPTH = khrs_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  khrs_pkg::q_entry_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output khrs_pkg::q_entry_t head_o,
  output logic               empty_o
);
  import khrs_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("queue count beyond depth");

endmodule

FILE: rtl/khrs_back.sv
// back end: numbers reported segments and drives the result register
module khrs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  khrs_pkg::q_entry_t head_i,
  input  logic               empty_i,
  output logic               pop_o,
  khrs_out_if.source         out_o
);
  import khrs_pkg::*;

  logic               phase_q, phase_d;
  logic [ID_W-1:0]    next_id_q, next_id_d;
  logic               out_valid_q, out_valid_d;
  logic               seg_valid_q, seg_valid_d;
  seg_t               seg_q, seg_d;
  logic [ID_W-1:0]    mapped_id_q, mapped_id_d;
  logic [RID_W-1:0]   rid_q, rid_d;
  logic               done_q, done_d;
  logic               load;
  logic               last;
  logic               sel_valid;
  seg_t               sel_seg;

  assign load = !empty_i && (!out_valid_q || out_o.ready);
  assign last = phase_q || !(head_i.has_a && head_i.has_b);

  always_comb begin
    if (phase_q) begin
      sel_valid = 1'b1;
      sel_seg   = head_i.seg_b;
    end else if (head_i.has_a) begin
      sel_valid = 1'b1;
      sel_seg   = head_i.seg_a;
    end else if (head_i.has_b) begin
      sel_valid = 1'b1;
      sel_seg   = head_i.seg_b;
    end else begin
      sel_valid = 1'b0;
      sel_seg   = '0;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    next_id_d   = next_id_q;
    out_valid_d = out_valid_q && !out_o.ready;
    seg_valid_d = seg_valid_q;
    seg_d       = seg_q;
    mapped_id_d = mapped_id_q;
    rid_d       = rid_q;
    done_d      = done_q;
    if (load) begin
      phase_d     = !last;
      out_valid_d = 1'b1;
      seg_valid_d = sel_valid;
      seg_d       = sel_seg;
      mapped_id_d = sel_valid ? next_id_q : '0;
      rid_d       = head_i.read_index;
      done_d      = head_i.read_end && last;
      if (sel_valid) begin
        next_id_d = next_id_q + ID_STEP;
      end
    end
  end

  assign pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      next_id_q   <= FIRST_ID;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      next_id_q   <= next_id_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_valid_q <= seg_valid_d;
    seg_q       <= seg_d;
    mapped_id_q <= mapped_id_d;
    rid_q       <= rid_d;
    done_q      <= done_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.seg_valid      = seg_valid_q;
  assign out_o.seg_node       = seg_q.node;
  assign out_o.seg_reverse    = seg_q.reverse;
  assign out_o.seg_first_pos  = seg_q.start_pos;
  assign out_o.seg_last_pos   = seg_q.end_pos;
  assign out_o.seg_count      = seg_q.count;
  assign out_o.mapped_id      = mapped_id_q;
  assign out_o.out_read_index = rid_q;
  assign out_o.read_done      = done_q;

  a_second_has_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (!empty_i && head_i.has_a && head_i.has_b))
    else $error("second result without a pair of segments");

  a_id_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q[0])
    else $error("next mapped id is even");

  a_done_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !seg_valid_q) |-> (done_q && (mapped_id_q == '0)))
    else $error("empty result that does not close a read");

endmodule

FILE: rtl/kmer_hit_run_segmenter_core.sv
// k-mer hit run segmenter top level
// order: a hit transfer is written into the queue, then loaded into the result register
// throughput: one hit per cycle while the queue is not full; a hit that closes two
//   segments holds the result register for two results, the queue absorbs the difference
// reset: no open segment, next mapped id 1, minimum count 4, queue empty
module kmer_hit_run_segmenter_core #(
  parameter int unsigned QUEUE_DEPTH = khrs_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  khrs_in_if.sink    in_i,
  khrs_cfg_if.sink   cfg_i,
  khrs_out_if.source out_o
);
  import khrs_pkg::*;

  q_entry_t push_data;
  q_entry_t head;
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;

  khrs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_full_i (full),
    .q_push_o (push),
    .q_data_o (push_data)
  );

  khrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  khrs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the k-mer hit run segmenter core
`timescale 1ns / 1ps

module testbench;
  import khrs_pkg::*;

  typedef struct packed {
    logic                     hit;
    logic signed [NODE_W-1:0] node;
    logic [POS_W-1:0]         pos;
    logic                     fwd;
    logic [RID_W-1:0]         rid;
    logic                     last;
  } kmer_t;

  typedef struct packed {
    logic                     seg_valid;
    logic signed [NODE_W-1:0] node;
    logic                     reverse;
    logic [POS_W-1:0]         start_pos;
    logic [POS_W-1:0]         end_pos;
    logic [COUNT_W-1:0]       count;
    logic [ID_W-1:0]          id;
    logic [RID_W-1:0]         rid;
    logic                     done;
  } seg_rec_t;

  logic clk_i;
  logic rst_ni;

  khrs_in_if  in_if ();
  khrs_cfg_if cfg_if ();
  khrs_out_if out_if ();

  kmer_hit_run_segmenter_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  kmer_t    kmer_q[$];
  seg_rec_t seg_exp_q[$];

  // segmenter state as predicted
  logic [NODE_W-1:0]  open_node;
  logic               open_rev;
  logic [POS_W-1:0]   open_first;
  logic [POS_W-1:0]   open_last;
  logic [COUNT_W-1:0] open_cnt;
  logic [ID_W-1:0]    id_next;
  logic [COUNT_W-1:0] min_hits;

  int unsigned errors;
  int unsigned kmers_pushed;
  int unsigned kmers_taken;
  int unsigned in_wait;
  int unsigned out_hold;
  bit          in_took;
  bit          in_idle_on;
  bit          out_stall_on;
  kmer_t       drv_k;
  kmer_t       mon_k;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  task automatic report(input string what);
    errors++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic open_seg(input logic [NODE_W-1:0] nd, input logic [POS_W-1:0] pos);
    open_node  = nd;
    open_first = pos;
    open_last  = pos;
    open_cnt   = COUNT_W'(1);
  endtask

  task automatic close_seg(input logic [RID_W-1:0] rid, inout int n);
    seg_rec_t r;
    if (open_cnt >= min_hits) begin
      r           = '0;
      r.seg_valid = 1'b1;
      r.node      = open_node;
      r.reverse   = open_rev;
      r.start_pos = open_first;
      r.end_pos   = open_last;
      r.count     = open_cnt;
      r.id        = id_next;
      r.rid       = rid;
      seg_exp_q   = {seg_exp_q, r};
      id_next = id_next + ID_STEP;
      n++;
    end
  endtask

  task automatic segment_kmer(input kmer_t k);
    logic [NODE_W-1:0] nd;
    seg_rec_t          r;
    int                n;
    n  = 0;
    nd = k.node;
    if (k.hit && nd != '0) begin
      if (open_node == '0) begin
        open_rev = nd[NODE_W-1] ^ ~k.fwd;
        open_seg(nd, k.pos);
      end else if (nd != open_node) begin
        close_seg(k.rid, n);
        open_seg(nd, k.pos);
      end else begin
        if (open_cnt != COUNT_MAX) begin
          open_cnt = open_cnt + 1'b1;
        end
        open_last = k.pos;
      end
    end
    if (k.last) begin
      if (open_node != '0) begin
        close_seg(k.rid, n);
      end
      if (n == 0) begin
        r     = '0;
        r.rid = k.rid;
      end else begin
        r = seg_exp_q[$];
        seg_exp_q.delete(seg_exp_q.size() - 1);
      end
      r.done = 1'b1;
      seg_exp_q  = {seg_exp_q, r};
      open_node  = '0;
      open_rev   = 1'b0;
      open_first = '0;
      open_last  = '0;
      open_cnt   = '0;
    end
  endtask

  task automatic check_segment();
    seg_rec_t e;
    if (seg_exp_q.size() == 0) begin
      report($sformatf("segment for read %0h with nothing expected",
                       out_if.out_read_index));
    end else begin
      e = seg_exp_q.pop_front();
      check_field("seg_valid", out_if.seg_valid, e.seg_valid);
      check_field("seg_node", out_if.seg_node, e.node);
      check_field("seg_reverse", out_if.seg_reverse, e.reverse);
      check_field("seg_first_pos", out_if.seg_first_pos, e.start_pos);
      check_field("seg_last_pos", out_if.seg_last_pos, e.end_pos);
      check_field("seg_count", out_if.seg_count, e.count);
      check_field("mapped_id", out_if.mapped_id, e.id);
      check_field("out_read_index", out_if.out_read_index, e.rid);
      check_field("read_done", out_if.read_done, e.done);
    end
  endtask

  // hit transfers feed the predictor, segment transfers are checked
  always @(posedge clk_i) begin
    in_took = rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && out_if.valid && out_if.ready) begin
      check_segment();
    end
    if (in_took) begin
      mon_k.hit  = in_if.hit;
      mon_k.node = in_if.hit_node;
      mon_k.pos  = in_if.hit_pos;
      mon_k.fwd  = in_if.kmer_forward;
      mon_k.rid  = in_if.read_index;
      mon_k.last = in_if.read_end;
      segment_kmer(mon_k);
      kmers_taken++;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_took) begin
      in_if.valid <= 1'b1;
    end else if (in_wait != 0) begin
      in_if.valid <= 1'b0;
      in_wait--;
    end else if (kmer_q.size() != 0) begin
      drv_k = kmer_q.pop_front();
      in_if.hit          <= drv_k.hit;
      in_if.hit_node     <= drv_k.node;
      in_if.hit_pos      <= drv_k.pos;
      in_if.kmer_forward <= drv_k.fwd;
      in_if.read_index   <= drv_k.rid;
      in_if.read_end     <= drv_k.last;
      in_if.valid        <= 1'b1;
      if (in_idle_on) begin
        in_wait = pause_len();
      end
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (out_hold != 0) begin
      out_if.ready <= 1'b0;
      out_hold--;
    end else begin
      out_if.ready <= 1'b1;
      if (out_stall_on && $urandom_range(0, 3) == 0) begin
        out_hold = pause_len();
      end
    end
  end

  task automatic push_kmer(input logic hit, input logic [NODE_W-1:0] nd,
                           input logic [POS_W-1:0] pos, input logic fwd,
                           input logic [RID_W-1:0] rid, input logic last);
    kmer_t k;
    k.hit  = hit;
    k.node = nd;
    k.pos  = pos;
    k.fwd  = fwd;
    k.rid  = rid;
    k.last = last;
    kmer_q = {kmer_q, k};
    kmers_pushed++;
  endtask

  task automatic settle();
    do begin
      @(negedge clk_i);
    end while (kmers_taken != kmers_pushed || seg_exp_q.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_min(input logic [COUNT_W-1:0] v);
    @(negedge clk_i);
    cfg_if.valid     <= 1'b1;
    cfg_if.min_count <= v;
    do begin
      @(posedge clk_i);
    end while (!cfg_if.ready);
    min_hits = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [NODE_W-1:0] pick_node();
    logic [NODE_W-1:0] nd;
    case ($urandom_range(0, 9))
      0: nd = 32'h8000_0000;
      1: nd = 32'h7FFF_FFFF;
      2: nd = 32'hFFFF_FFFF;
      3: nd = 32'h0000_0001;
      default: nd = $urandom;
    endcase
    if (nd == '0) begin
      nd = 32'h0000_0002;
    end
    return nd;
  endfunction

  task automatic gen_read(input int unsigned m);
    logic [RID_W-1:0]  rid;
    logic [NODE_W-1:0] nd;
    logic [POS_W-1:0]  pos;
    int unsigned       segs;
    int unsigned       run;
    rid = RID_W'({$urandom, $urandom});
    nd  = pick_node();
    if ($urandom_range(0, 9) == 0) begin
      // broken read: misses and stray hits only
      repeat ($urandom_range(0, 3)) begin
        push_kmer(1'($urandom_range(0, 1)), $urandom, $urandom,
                  1'($urandom_range(0, 1)), rid, 1'b0);
      end
      push_kmer(1'($urandom_range(0, 1)), $urandom, $urandom,
                1'($urandom_range(0, 1)), rid, 1'b1);
      return;
    end
    segs = $urandom_range(1, 4);
    repeat (segs) begin
      if ($urandom_range(0, 4) != 0) begin
        nd = pick_node();
      end
      run = (m <= 12) ? $urandom_range(1, m + 3) : $urandom_range(1, 6);
      pos = $urandom;
      repeat (run) begin
        if ($urandom_range(0, 5) == 0) begin
          push_kmer(1'b0, $urandom, $urandom, 1'($urandom_range(0, 1)), rid, 1'b0);
        end
        if ($urandom_range(0, 19) == 0) begin
          push_kmer(1'b1, '0, $urandom, 1'($urandom_range(0, 1)), rid, 1'b0);
        end
        if ($urandom_range(0, 29) == 0) begin
          rid = RID_W'({$urandom, $urandom});
        end
        push_kmer(1'b1, nd, pos, 1'($urandom_range(0, 1)), rid, 1'b0);
        pos = ($urandom_range(0, 3) == 0) ? $urandom : pos + 1'b1;
      end
    end
    case ($urandom_range(0, 2))
      0: push_kmer(1'b0, $urandom, $urandom, 1'($urandom_range(0, 1)), rid, 1'b1);
      1: push_kmer(1'b1, nd, pos, 1'($urandom_range(0, 1)), rid, 1'b1);
      default: push_kmer(1'b1, pick_node(), pos, 1'($urandom_range(0, 1)), rid, 1'b1);
    endcase
  endtask

  task automatic random_phase(input logic [COUNT_W-1:0] m, input bit idle_in,
                              input bit idle_out);
    int unsigned start;
    write_min(m);
    in_idle_on   = idle_in;
    out_stall_on = idle_out;
    start = kmers_pushed;
    while (kmers_pushed - start < 155) begin
      gen_read(m);
    end
    settle();
  endtask

  initial begin
    errors       = 0;
    kmers_pushed = 0;
    kmers_taken  = 0;
    in_wait      = 0;
    out_hold     = 0;
    in_took      = 1'b0;
    in_idle_on   = 1'b0;
    out_stall_on = 1'b0;
    open_node    = '0;
    open_rev     = 1'b0;
    open_first   = '0;
    open_last    = '0;
    open_cnt     = '0;
    id_next      = FIRST_ID;
    min_hits     = MIN_MATCHES_RST;

    in_if.valid        = 1'b0;
    in_if.hit          = 1'b0;
    in_if.hit_node     = '0;
    in_if.hit_pos      = '0;
    in_if.kmer_forward = 1'b0;
    in_if.read_index   = '0;
    in_if.read_end     = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.min_count   = '0;
    out_if.ready       = 1'b0;
    rst_ni             = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset minimum: empty read, two reported segments, short one dropped
    push_kmer(1'b0, '0, '0, 1'b0, 40'hFF_FFFF_FFFF, 1'b1);
    push_kmer(1'b1, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '0, 1'b0);
    push_kmer(1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0, 1'b0);
    push_kmer(1'b1, 32'h7FFF_FFFF, 32'h0000_0005, 1'b1, '0, 1'b0);
    push_kmer(1'b1, 32'h7FFF_FFFF, 32'h0000_0006, 1'b1, '0, 1'b0);
    push_kmer(1'b1, '0, 32'h1234_5678, 1'b0, '0, 1'b0);
    push_kmer(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0, 1'b0);
    push_kmer(1'b1, 32'h8000_0000, 32'h0000_0001, 1'b0, '0, 1'b0);
    push_kmer(1'b1, 32'h8000_0000, 32'h0000_0002, 1'b0, '0, 1'b0);
    push_kmer(1'b1, 32'h8000_0000, 32'h0000_0003, 1'b1, '0, 1'b0);
    push_kmer(1'b1, 32'h8000_0000, 32'h0000_0004, 1'b0, 40'h00_0000_0007, 1'b1);
    push_kmer(1'b1, 32'h0000_0001, 32'h0000_0010, 1'b0, 40'h80_0000_0000, 1'b0);
    push_kmer(1'b1, 32'h0000_0001, 32'h0000_0011, 1'b1, 40'h80_0000_0000, 1'b0);
    push_kmer(1'b0, 32'h0000_0001, 32'h0000_0012, 1'b1, 40'h80_0000_0000, 1'b1);
    settle();

    // minimum of one: two segments from one end transfer, node zero at read end
    write_min(COUNT_W'(1));
    push_kmer(1'b1, 32'hFFFF_FFFF, 32'h0000_0100, 1'b0, 40'h00_0000_0001, 1'b0);
    push_kmer(1'b1, 32'h0000_0002, 32'h0000_0200, 1'b1, 40'h00_0000_0002, 1'b1);
    push_kmer(1'b1, '0, 32'h0000_0300, 1'b1, 40'h00_0000_0003, 1'b1);
    push_kmer(1'b1, 32'h0000_0005, 32'h0000_0400, 1'b1, 40'h00_0000_000A, 1'b0);
    push_kmer(1'b1, 32'h0000_0005, 32'h0000_0401, 1'b0, 40'h00_0000_000B, 1'b1);
    settle();

    random_phase(COUNT_W'(2), 1'b1, 1'b1);
    random_phase(COUNT_W'(3), 1'b0, 1'b0);
    random_phase(COUNT_W'(0), 1'b1, 1'b0);
    random_phase(COUNT_W'(5), 1'b0, 1'b1);
    random_phase(COUNT_W'(1), 1'b1, 1'b1);
    random_phase(MIN_MATCHES_RST, 1'b1, 1'b1);
    random_phase(COUNT_W'($urandom_range(2, 8)), 1'b1, 1'b1);
    random_phase(COUNT_W'($urandom_range(100, 65534)), 1'b1, 1'b1);
    random_phase(COUNT_W'($urandom_range(2, 6)), 1'b1, 1'b1);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
